[hdl/liu_pkg.sv]
// Shared types and constants for the linear interpolation upsampler.
package liu_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int FACTOR_W    = 7;
    localparam int REM_W       = FACTOR_W - 1;
    localparam int DIV_STEPS   = DIFF_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] cur;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIFF,
        BK_ABS,
        BK_DIV,
        BK_SETUP,
        BK_RUN
    } t_back_state;

endpackage

[hdl/liu_front.sv]
// Front end: accept samples, pair each with its predecessor, push a job.
module liu_front
    import liu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_in_stall,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output t_job                       o_job
);

    logic                       r_have_prev;
    logic signed [SAMPLE_W-1:0] r_prev;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // First sample after reset interpolates against itself.
    assign o_job.cur  = i_sample_value;
    assign o_job.prev = r_have_prev ? r_prev : i_sample_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev <= i_sample_value;
        end
    end

endmodule

[hdl/liu_queue.sv]
// Small job queue between the front end and the interpolation engine.
module liu_queue
    import liu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hdl/liu_back.sv]
// Back end: divide the step, then walk the run one result per unstalled cycle.
module liu_back
    import liu_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [FACTOR_W-1:0]        i_factor,
    input  logic                       i_job_valid,
    input  t_job                       i_job,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_value,
    output logic                       o_run_last
);

    t_back_state r_state;
    t_back_state n_state;

    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic [FACTOR_W-1:0]        r_f;
    logic signed [DIFF_W-1:0]   r_diff;
    logic                       r_neg;
    logic [DIFF_W-1:0]          r_dvd;
    logic [REM_W-1:0]           r_rem;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic [SAMPLE_W-1:0]        r_step;
    logic [SAMPLE_W-1:0]        r_step_p;
    logic [SAMPLE_W-1:0]        r_acc;
    logic [REM_W-1:0]           r_racc;
    logic [FACTOR_W-1:0]        r_run_cnt;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_value;
    logic                       r_run_last;

    logic                  w_gen;
    logic                  w_div_done;
    logic                  w_last;
    logic [FACTOR_W-1:0]   w_shift;
    logic                  w_ge;
    logic [FACTOR_W-1:0]   w_rsum;
    logic                  w_wrap;
    logic [REM_W-1:0]      n_racc;
    logic [SAMPLE_W-1:0]   n_acc;
    logic [SAMPLE_W-1:0]   w_q_lo;

    assign w_div_done = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign w_last     = (r_run_cnt == r_f - 1'b1);

    // One restoring division step per cycle.
    assign w_shift = {r_rem, r_dvd[DIFF_W-1]};
    assign w_ge    = (w_shift >= r_f);

    // Fractional part of i*|diff|/F accumulates in r_racc, carrying into the sum.
    assign w_rsum = {1'b0, r_racc} + {1'b0, r_rem};
    assign w_wrap = (w_rsum >= r_f);
    assign n_racc = w_wrap ? REM_W'(w_rsum - r_f) : w_rsum[REM_W-1:0];
    assign n_acc  = r_acc + (w_wrap ? r_step_p : r_step);

    assign w_q_lo = r_dvd[SAMPLE_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (i_job_valid) n_state = BK_DIFF;
            BK_DIFF:  n_state = BK_ABS;
            BK_ABS:   n_state = BK_DIV;
            BK_DIV:   if (w_div_done) n_state = BK_SETUP;
            BK_SETUP: n_state = BK_RUN;
            BK_RUN:   if (w_gen && w_last) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        w_gen = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop = i_job_valid;
            BK_RUN:  w_gen = !r_out_valid || !i_out_stall;
            default: begin
                o_pop = 1'b0;
                w_gen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_gen) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_prev <= i_job.prev;
                r_cur  <= i_job.cur;
                r_f    <= i_factor;
            end
            BK_DIFF: begin
                r_diff <= DIFF_W'(r_cur) - DIFF_W'(r_prev);
            end
            BK_ABS: begin
                r_neg     <= r_diff[DIFF_W-1];
                r_dvd     <= r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
                r_rem     <= '0;
                r_div_cnt <= '0;
            end
            BK_DIV: begin
                r_rem     <= w_ge ? REM_W'(w_shift - r_f) : w_shift[REM_W-1:0];
                r_dvd     <= {r_dvd[DIFF_W-2:0], w_ge};
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            BK_SETUP: begin
                // Signed step and the step one unit further from zero, modulo 2^32.
                r_step    <= r_neg ? (~w_q_lo + 1'b1) : w_q_lo;
                r_step_p  <= r_neg ? ~w_q_lo : (w_q_lo + 1'b1);
                r_acc     <= r_prev;
                r_racc    <= '0;
                r_run_cnt <= '0;
            end
            BK_RUN: begin
                if (w_gen) begin
                    r_acc       <= n_acc;
                    r_racc      <= n_racc;
                    r_run_cnt   <= r_run_cnt + 1'b1;
                    r_out_value <= n_acc;
                    r_run_last  <= w_last;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_run_last  = r_run_last;

endmodule

[hdl/linear_interp_upsampler.sv]
// Top level of the linear interpolation upsampler.
//
// Each accepted Q16.16 sample produces a run of F results, F being the
// upsample factor register (0 acts as 1, values above MAX_FACTOR clamp to
// MAX_FACTOR). The first sample after reset repeats itself F times; every
// later sample gives prev + trunc(i*(cur-prev)/F) for i = 1..F, so a run
// ends exactly on the new sample, and its final result carries run_last.
// One item occupies the interpolation engine while it takes the job, forms
// |cur - prev| as a difference and then its absolute value, runs the
// bit-serial divider that splits it into quotient and remainder by F, sets
// up the step, then gives one result per cycle while the output is not
// stalled. The front end and a two-entry job queue accept up to two further
// samples meanwhile, so input stall rises only when both queue slots are
// full. Results pass through an output register; a stall while a result
// is held freezes that register and the run. Write the factor only while
// the block is idle; the configuration port is always ready.
module linear_interp_upsampler
    import liu_pkg::*;
#(
    parameter int MAX_FACTOR = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sample input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    // Result output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_value,
    output logic                       o_run_last,
    // Factor register write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [FACTOR_W-1:0]        i_cfg_data
);

    localparam logic [FACTOR_W-1:0] MaxF = FACTOR_W'(MAX_FACTOR);

    logic [FACTOR_W-1:0] r_factor;
    logic [FACTOR_W-1:0] w_eff_factor;

    logic w_queue_full;
    logic w_push;
    t_job w_push_job;
    logic w_job_valid;
    t_job w_job;
    logic w_pop;

    // Register write: always take the transaction.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_factor <= i_cfg_data;
        end
    end

    // Clamp the factor into 1..MAX_FACTOR.
    always_comb begin
        priority if (r_factor == '0) begin
            w_eff_factor = FACTOR_W'(1);
        end else if (r_factor > MaxF) begin
            w_eff_factor = MaxF;
        end else begin
            w_eff_factor = r_factor;
        end
    end

    // Accept samples and pair them with their predecessor.
    liu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_sample_value (i_sample_value),
        .o_in_stall     (o_in_stall),
        .i_queue_full   (w_queue_full),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // Decouple acceptance from the long-running engine.
    liu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job)
    );

    // Divide, then emit the run.
    liu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_factor    (w_eff_factor),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_run_last  (o_run_last)
    );

endmodule

[hdl/liu_checker.sv]
// Port-level checks for the linear interpolation upsampler, with bind.
module liu_checker
    import liu_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_out_value,
    input logic                       o_run_last
);

    logic r_seen_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_in <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_seen_in <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_value) && $stable(o_run_last))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_seen_in)
        else $error("result before any sample transaction");

endmodule

bind linear_interp_upsampler liu_checker u_liu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_value    (o_out_value),
    .o_run_last     (o_run_last)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the linear interpolation upsampler.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import liu_pkg::SAMPLE_W;
    import liu_pkg::FACTOR_W;

    localparam int MAX_FACTOR    = 64;
    localparam int SETTLE_CYCLES = 4;    // idle margin before a factor write
    localparam int HOLD_CYCLES   = 600;  // long receiver hold-off
    localparam int TAIL_CYCLES   = 120;  // margin longer than one engine job at MAX_FACTOR

    // Plan steps: what the driver does next, in order.
    typedef enum logic [2:0] {
        STEP_SAMPLE,  // offer one sample transaction
        STEP_DRAIN,   // pause until every expected point has arrived
        STEP_FACTOR,  // write the factor register once the block is idle
        STEP_PACE,    // change sender idle and receiver stall rates
        STEP_HOLD     // start one long receiver hold-off
    } t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        logic [SAMPLE_W-1:0] value;
        logic [6:0]          send_pct;
        logic [6:0]          stall_pct;
    } t_plan_step;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_expected_point;

    // DUT connections
    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       o_out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_out_value;
    logic                       o_run_last;
    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [FACTOR_W-1:0]        cfg_data  = '0;

    // Stimulus plan and scoreboard
    t_plan_step      plan_q[$];
    t_expected_point expected_points[$];

    // Predictor state: mirrors the block's factor register and sample history
    logic [FACTOR_W-1:0]        factor_reg = 7'd1;
    logic signed [SAMPLE_W-1:0] last_input = '0;
    logic                       seen_input = 1'b0;

    // Handshake flags seen at the last rising edge
    logic sample_taken = 1'b0;
    logic factor_taken = 1'b0;

    // Pacing
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_go       = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    // Bookkeeping
    int fail_count    = 0;
    int samples_sent  = 0;
    int points_seen   = 0;
    int factor_writes = 0;
    int input_stalls  = 0;

    linear_interp_upsampler #(
        .MAX_FACTOR(MAX_FACTOR)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_value(sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_value   (o_out_value),
        .o_run_last    (o_run_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Append one step to the plan.
    function automatic void plan(t_step_kind kind, logic [SAMPLE_W-1:0] value = '0,
                                 int send = 0, int stall = 0);
        t_plan_step s;
        s.kind      = kind;
        s.value     = value;
        s.send_pct  = 7'(send);
        s.stall_pct = 7'(stall);
        plan_q.push_back(s);
    endfunction

    // Compute the run of points one sample produces. The factor clamps to
    // 1..MAX_FACTOR; the first sample after reset interpolates from itself,
    // so its run just repeats it. Division truncates toward zero.
    function automatic void predict_run(logic signed [SAMPLE_W-1:0] cur);
        longint          f;
        longint          base;
        longint          span;
        longint          point;
        t_expected_point e;
        f = longint'(factor_reg);
        if (f == 0) f = 1;
        if (f > MAX_FACTOR) f = MAX_FACTOR;
        base = seen_input ? longint'(last_input) : longint'(cur);
        span = longint'(cur) - base;
        for (longint i = 1; i <= f; i++) begin
            point   = base + (span * i) / f;
            e.value = point[SAMPLE_W-1:0];
            e.last  = (i == f);
            expected_points.push_back(e);
        end
        last_input = cur;
        seen_input = 1'b1;
    endfunction

    // Driver: change inputs on the falling edge. Hold a stalled transaction,
    // otherwise take the next plan step.
    always @(negedge i_clk) begin
        logic                nv;
        logic [SAMPLE_W-1:0] ns;
        logic                ncv;
        logic [FACTOR_W-1:0] nd;
        logic                hg;
        t_plan_step          head;
        nv  = in_valid && !sample_taken;
        ns  = sample;
        ncv = cfg_valid && !factor_taken;
        nd  = cfg_data;
        hg  = 1'b0;
        // Count cycles with nothing in flight and nothing owed by the block.
        if (expected_points.size() == 0 && !nv && !ncv) begin
            quiet_cycles = quiet_cycles + 1;
        end else begin
            quiet_cycles = 0;
        end
        if (i_rst_n && !nv && !ncv && plan_q.size() != 0) begin
            head = plan_q[0];
            case (head.kind)
                STEP_SAMPLE: begin
                    if ($urandom_range(0, 99) >= send_idle_pct) begin
                        nv = 1'b1;
                        ns = head.value;
                        void'(plan_q.pop_front());
                    end
                end
                STEP_DRAIN: begin
                    if (quiet_cycles >= SETTLE_CYCLES) void'(plan_q.pop_front());
                end
                STEP_FACTOR: begin
                    // Write the factor only while the block is idle.
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        ncv = 1'b1;
                        nd  = head.value[FACTOR_W-1:0];
                        void'(plan_q.pop_front());
                    end
                end
                STEP_PACE: begin
                    send_idle_pct = 32'(head.send_pct);
                    stall_pct    <= 32'(head.stall_pct);
                    void'(plan_q.pop_front());
                end
                STEP_HOLD: begin
                    hg = 1'b1;
                    void'(plan_q.pop_front());
                end
                default: void'(plan_q.pop_front());
            endcase
        end
        in_valid  <= nv;
        sample    <= ns;
        cfg_valid <= ncv;
        cfg_data  <= nd;
        hold_go   <= hg;
    end

    // Receiver: stall at random, or for a long counted stretch on request.
    always @(negedge i_clk) begin
        int unsigned left;
        left = hold_left;
        if (hold_go) begin
            left = HOLD_CYCLES;
        end else if (left != 0) begin
            left = left - 1;
        end
        hold_left <= left;
        out_stall <= i_rst_n && (left != 0 || $urandom_range(0, 99) < stall_pct);
    end

    // Monitor: sample every channel on the rising edge. Update the predictor
    // on accepted config and sample transactions, check accepted results.
    always @(posedge i_clk) begin
        t_expected_point want;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
            factor_taken <= 1'b0;
        end else begin
            sample_taken <= in_valid && !o_in_stall;
            factor_taken <= cfg_valid && o_cfg_ready;
            if (cfg_valid && o_cfg_ready) begin
                factor_reg    = cfg_data;
                factor_writes = factor_writes + 1;
            end
            if (in_valid && !o_in_stall) begin
                predict_run(sample);
                samples_sent = samples_sent + 1;
            end
            if (in_valid && o_in_stall) input_stalls = input_stalls + 1;
            if (o_out_valid && !out_stall) begin
                points_seen = points_seen + 1;
                if (expected_points.size() == 0) begin
                    $error("out_value: unexpected result %0d, run_last %0b, none pending",
                           o_out_value, o_run_last);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (o_out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, o_out_value);
                        fail_count = fail_count + 1;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // Build the plan, release reset, then wait for everything to drain.
    initial begin
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] prev_s;
        int                         f;

        // Directed: the reset factor with the first-sample repeat, factor 0
        // acting as 1, values above the maximum clamping, full-scale swings
        // both ways, and truncation toward zero on rising and falling spans.
        plan(STEP_PACE, '0, 0, 0);
        plan(STEP_SAMPLE, 32'sh0001_8000);
        plan(STEP_SAMPLE, -32'sd1);
        plan(STEP_FACTOR, 0);
        plan(STEP_SAMPLE, 32'sh8000_0000);
        plan(STEP_SAMPLE, 32'sh7FFF_FFFF);
        plan(STEP_FACTOR, 127);
        plan(STEP_SAMPLE, 32'sh8000_0000);
        plan(STEP_SAMPLE, 32'sh7FFF_FFFF);
        plan(STEP_SAMPLE, 32'sh0000_0000);
        plan(STEP_FACTOR, 3);
        plan(STEP_SAMPLE, -32'sd7);
        plan(STEP_SAMPLE, 32'sd0);
        plan(STEP_SAMPLE, 32'sd7);
        plan(STEP_SAMPLE, 32'sd5);
        plan(STEP_FACTOR, MAX_FACTOR);
        plan(STEP_SAMPLE, 32'sh0010_0000);
        plan(STEP_SAMPLE, 32'shFFF0_0000);
        plan(STEP_SAMPLE, 32'sh5555_5555);
        plan(STEP_SAMPLE, 32'shAAAA_AAAA);
        plan(STEP_FACTOR, MAX_FACTOR + 1);
        plan(STEP_SAMPLE, -32'sd1);
        plan(STEP_SAMPLE, 32'sd0);
        plan(STEP_FACTOR, 1);
        plan(STEP_SAMPLE, 32'sd12345);
        prev_s = 32'sd12345;

        // Random: twelve segments, each with its own factor and one of the
        // four pacing modes. Factors lean small to keep runs short.
        for (int seg = 0; seg < 12; seg++) begin
            case ($urandom_range(0, 9))
                6:       f = $urandom_range(9, MAX_FACTOR - 1);
                7:       f = MAX_FACTOR;
                8:       f = $urandom_range(MAX_FACTOR + 1, 127);
                9:       f = 0;
                default: f = $urandom_range(1, 8);
            endcase
            plan(STEP_FACTOR, f);
            case (seg % 4)
                0:       plan(STEP_PACE, '0, 0, 0);
                1:       plan(STEP_PACE, '0, 78, 0);
                2:       plan(STEP_PACE, '0, 0, 78);
                default: plan(STEP_PACE, '0, 23, 23);
            endcase
            for (int n = 0; n < 35; n++) begin
                if ($urandom_range(0, 29) == 0) plan(STEP_DRAIN);
                case ($urandom_range(0, 3))
                    2: s = prev_s + $urandom_range(0, 2000) - 1000;
                    3: begin
                        case ($urandom_range(0, 3))
                            0:       s = 32'sh8000_0000;
                            1:       s = 32'sh7FFF_FFFF;
                            2:       s = 32'sd0;
                            default: s = -32'sd1;
                        endcase
                    end
                    default: s = $urandom;
                endcase
                plan(STEP_SAMPLE, s);
                prev_s = s;
            end
        end

        // Backpressure: hold the receiver off while the sender keeps going,
        // so the job queue fills and the input stalls, then drain fully.
        plan(STEP_DRAIN);
        plan(STEP_FACTOR, MAX_FACTOR);
        plan(STEP_PACE, '0, 0, 0);
        plan(STEP_HOLD);
        for (int n = 0; n < 8; n++) plan(STEP_SAMPLE, $urandom);
        plan(STEP_DRAIN);
        plan(STEP_SAMPLE, $urandom);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() != 0 || in_valid || cfg_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples, %0d points checked, %0d factor writes,",
                 samples_sent, points_seen, factor_writes);
        $display("factors 0 to 127 and %0d cycles of input backpressure.", input_stalls);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
